FILE: sv/bmvs_pkg.sv
// Package for the vehicle step core: Q16.16 constants, command codes, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bmvs_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX = 30;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_ACCEL = 3'd1;
  localparam logic [2:0] FUNC_BRAKE = 3'd2;
  localparam logic [2:0] FUNC_LEFT  = 3'd3;
  localparam logic [2:0] FUNC_RIGHT = 3'd4;
  localparam logic [2:0] FUNC_STOP  = 3'd5;

  localparam logic [2:0] REG_THROTTLE_GAIN = 3'd0;
  localparam logic [2:0] REG_IDLE_FORCE    = 3'd1;
  localparam logic [2:0] REG_BRAKE_SMOOTH  = 3'd2;
  localparam logic [2:0] REG_STATIC_BRAKE  = 3'd3;
  localparam logic [2:0] REG_DYNAMIC_BRAKE = 3'd4;
  localparam logic [2:0] REG_DRAG          = 3'd5;
  localparam logic [2:0] REG_INV_MASS      = 3'd6;
  localparam logic [2:0] REG_INV_WHEELBASE = 3'd7;

  localparam logic signed [31:0] Q_ONE       = 32'sd65536;
  localparam logic signed [31:0] NEAR_STOP   = 32'sd328;
  localparam logic signed [31:0] ONE_DEG     = 32'sd1144;
  localparam logic signed [31:0] STEER_LIMIT = 32'sd19661;
  localparam logic signed [31:0] BRAKE_HOLD  = 32'sd6554;
  localparam logic signed [31:0] PI_Q        = 32'sd205887;
  localparam logic signed [31:0] HALF_PI_Q   = 32'sd102944;
  localparam logic signed [31:0] TWO_PI_Q    = 32'sd411775;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] S32_MAX     = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN     = 32'sh80000000;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0: atan_entry = 34'sd843314856;  5'd1: atan_entry = 34'sd497837829;
      5'd2: atan_entry = 34'sd263043836;  5'd3: atan_entry = 34'sd133525158;
      5'd4: atan_entry = 34'sd67021686;   5'd5: atan_entry = 34'sd33543515;
      5'd6: atan_entry = 34'sd16775850;   5'd7: atan_entry = 34'sd8388437;
      5'd8: atan_entry = 34'sd4194282;    5'd9: atan_entry = 34'sd2097149;
      5'd10: atan_entry = 34'sd1048575;   5'd11: atan_entry = 34'sd524287;
      5'd12: atan_entry = 34'sd262143;    5'd13: atan_entry = 34'sd131071;
      5'd14: atan_entry = 34'sd65535;     5'd15: atan_entry = 34'sd32767;
      5'd16: atan_entry = 34'sd16383;     5'd17: atan_entry = 34'sd8191;
      5'd18: atan_entry = 34'sd4095;      5'd19: atan_entry = 34'sd2047;
      5'd20: atan_entry = 34'sd1023;      5'd21: atan_entry = 34'sd511;
      5'd22: atan_entry = 34'sd255;       5'd23: atan_entry = 34'sd127;
      5'd24: atan_entry = 34'sd63;        5'd25: atan_entry = 34'sd31;
      5'd26: atan_entry = 34'sd15;        5'd27: atan_entry = 34'sd7;
      5'd28: atan_entry = 34'sd3;         5'd29: atan_entry = 34'sd1;
      default: atan_entry = 34'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = S32_MAX;
    else if (v < -66'sd2147483648) sat32 = S32_MIN;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/bmvs_stream_if.sv
// Valid/ready stream interfaces for command beats and pose beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface bmvs_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [31:0] amount;
  logic [30:0]       time_step;
  modport source (output valid, func, amount, time_step, input ready);
  modport sink (input valid, func, amount, time_step, output ready);
endinterface

interface bmvs_pose_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  modport source (output valid, pos_x, pos_y, dir_x, dir_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, dir_x, dir_y, vel_x, vel_y, output ready);
endinterface
`default_nettype wire

FILE: sv/bmvs_cordic.sv
// Iterative rotation CORDIC: folds and rotates one angle, one step per cycle.
// Depends on bmvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmvs_cordic #(
  parameter int CORDIC_STEPS = bmvs_pkg::CORDIC_STEPS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire signed [31:0] angle,   // already within [-pi, pi]
  output logic              done,
  output logic signed [17:0] cos_q,
  output logic signed [17:0] sin_q
);
  localparam int NS = (CORDIC_STEPS < bmvs_pkg::CORDIC_MAX) ? CORDIC_STEPS
                                                            : bmvs_pkg::CORDIC_MAX;
  logic              busy;
  logic [4:0]        step;
  logic              flip;
  logic signed [33:0] x, y, z;
  logic signed [33:0] xs, ys, xn, yn, zn;
  logic signed [31:0] fold;
  logic               fflip;

  always_comb begin
    fflip = 1'b0;
    fold = angle;
    if (angle > bmvs_pkg::HALF_PI_Q) begin
      fold = angle - bmvs_pkg::PI_Q; fflip = 1'b1;
    end else if (angle < -bmvs_pkg::HALF_PI_Q) begin
      fold = angle + bmvs_pkg::PI_Q; fflip = 1'b1;
    end
    xs = x >>> step;
    ys = y >>> step;
    if (!z[33]) begin
      xn = x - ys; yn = y + xs; zn = z - bmvs_pkg::atan_entry(step);
    end else begin
      xn = x + ys; yn = y - xs; zn = z + bmvs_pkg::atan_entry(step);
    end
  end

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v, input logic f);
    logic signed [34:0] r;
    logic signed [17:0] c;
    r = (35'(v) + 35'sd8192) >>> 14;
    if (r > 35'sd65536) c = 18'sd65536;
    else if (r < -35'sd65536) c = -18'sd65536;
    else c = r[17:0];
    to_q16 = f ? -c : c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; step <= '0; flip <= fflip;
        x <= bmvs_pkg::CORDIC_GAIN; y <= '0;
        z <= 34'(fold) <<< 14;
      end else if (busy) begin
        x <= xn; y <= yn; z <= zn;
        if (step == 5'(NS - 1)) begin
          busy <= 1'b0; done <= 1'b1;
          cos_q <= to_q16(xn, flip);
          sin_q <= to_q16(yn, flip);
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/bmvs_divider.sv
// Restoring signed divider: 64-bit numerator by 18-bit divisor, one quotient bit a cycle.
// Truncates toward zero; quotient saturates to 32 bits signed. Depends on bmvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmvs_divider (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire signed [63:0] num,
  input  wire signed [17:0] den,
  output logic              done,
  output logic signed [31:0] quot
);
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] q;
  logic [64:0] rem;
  logic [16:0] d;
  logic        neg, nz, dz, nsign;
  logic [64:0] trial;
  logic [64:0] remsh;
  logic signed [65:0] sq;

  // quotient follows the held magnitude, so it is valid from the done cycle on
  always_comb begin
    remsh = {rem[63:0], q[63]};
    trial = remsh - 65'(d);
    sq = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (dz) begin
      if (!nz) quot = 32'sd0;
      else if (nsign) quot = bmvs_pkg::S32_MIN;
      else quot = bmvs_pkg::S32_MAX;
    end else begin
      quot = bmvs_pkg::sat32(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= '0; rem <= '0;
        q <= num[63] ? 64'(-num) : 64'(num);
        d <= den[17] ? 17'(-den) : 17'(den);
        neg <= num[63] ^ den[17];
        nsign <= num[63];
        nz <= (num != 64'sd0);
        dz <= (den == 18'sd0);
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial; q <= {q[62:0], 1'b1};
        end else begin
          rem <= remsh; q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/bicycle_model_vehicle_step_core.sv
// Top level of the vehicle step core: command handling, tick sequencer, shared multiplier.
// Depends on bmvs_pkg, bmvs_stream_if, bmvs_cordic, bmvs_divider.
//
// Usage:
//  cmd channel takes one beat per command (func, amount, time_step). Commands
//  other than a tick update the driver targets and send nothing.
//  A tick runs the force model, steering, position and heading update through
//  one shared 33x33 multiplier (one product a cycle, registered), three passes
//  of the iterative CORDIC, two angle reductions mod 2pi and a 64-bit divider.
//  cmd ready is low while a tick runs.
//  pose channel carries one beat per tick from an output register. While the
//  receiver stalls the pose beat holds; the next command is taken and run, and
//  a following tick waits only at its end until the held beat is taken.
//  Reset (synchronous, active high) restores register defaults and clears the
//  model state; brake_target resets to the holding value 0.1.
//  cfg writes take effect at once; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module bicycle_model_vehicle_step_core #(
  parameter int CORDIC_STEPS = bmvs_pkg::CORDIC_STEPS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  bmvs_cmd_if.sink   cmd,
  bmvs_pose_if.source pose,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [30:0] cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0, S_MOTOR = 5'd1, S_BEFF = 5'd2, S_BRAKE = 5'd3,
    S_DRAG1 = 5'd4, S_DRAG2 = 5'd5, S_ACC = 5'd6, S_SPD = 5'd7, S_STEER = 5'd8,
    S_TRIG1 = 5'd9, S_TPOS = 5'd10, S_PX = 5'd11, S_PY = 5'd12, S_TRIG2 = 5'd13,
    S_T1 = 5'd14, S_T2 = 5'd15, S_DIV = 5'd16, S_HEAD = 5'd17, S_TRIG3 = 5'd18,
    S_VX = 5'd19, S_VY = 5'd20, S_OUT = 5'd21, S_W1 = 5'd22, S_W2 = 5'd23, S_W3 = 5'd24;

  logic [4:0] state;
  // configuration
  logic [30:0] throttle_gain, idle_force, static_brake_gain, dynamic_brake_gain;
  logic [30:0] drag_coefficient, inverse_mass, inverse_wheelbase;
  logic [16:0] brake_smoothing;
  // model state
  logic signed [31:0] throttle_target, brake_target, brake_effort, speed, heading;
  logic signed [31:0] steer_angle, steer_target, position_x, position_y;
  // tick scratch
  logic [30:0] dt;
  logic signed [31:0] motor, brake, tmp, tpos;
  logic signed [17:0] ch, sh, ss, cs;

  // shared multiplier: operands chosen per state, product registered
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_w;
  logic signed [31:0] prod;
  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_MOTOR: begin ma = {2'b0, throttle_gain}; mb = 33'(throttle_target); end
      // differences kept at full 33-bit width, no saturation before the product
      S_BEFF:  begin ma = {16'b0, brake_smoothing};
                     mb = 33'(brake_target) - 33'(brake_effort); end
      S_BRAKE: begin ma = (speed < bmvs_pkg::NEAR_STOP) ? {2'b0, static_brake_gain}
                                                     : {2'b0, dynamic_brake_gain};
                     mb = 33'(brake_effort); end
      S_DRAG1: begin ma = {2'b0, drag_coefficient}; mb = 33'(speed); end
      S_DRAG2: begin ma = 33'(prod); mb = 33'(speed); end
      S_ACC:   begin ma = 33'(tmp); mb = {2'b0, inverse_mass}; end
      S_SPD:   begin ma = 33'(prod); mb = {2'b0, dt}; end
      S_STEER: begin ma = {2'b0, dt};
                     mb = 33'(steer_target) - 33'(steer_angle); end
      S_TPOS:  begin ma = {2'b0, dt}; mb = 33'(speed); end
      S_PX:    begin ma = 33'(prod); mb = 33'(ch); end
      S_PY:    begin ma = 33'(tpos); mb = 33'(sh); end
      S_T1:    begin ma = {2'b0, dt}; mb = {2'b0, inverse_wheelbase}; end
      S_T2:    begin ma = 33'(prod); mb = 33'(speed); end
      S_VX:    begin ma = 33'(ch); mb = 33'(speed); end
      // hold the last product steady while the output waits
      S_VY, S_OUT: begin ma = 33'(sh); mb = 33'(speed); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod_w = (ma * mb) >>> 16;
  end

  // CORDIC and divider
  logic        cor_start, cor_done, div_start, div_done;
  logic signed [31:0] cor_angle;
  logic signed [17:0] cor_c, cor_s;
  logic signed [31:0] quot;
  logic signed [63:0] num;
  logic [1:0]  cor_pass;

  bmvs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(cor_angle),
    .done(cor_done), .cos_q(cor_c), .sin_q(cor_s));
  bmvs_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(cs),
    .done(div_done), .quot(quot));

  // final wrap to [-pi, pi]; inputs here are already below 2pi in magnitude
  function automatic logic signed [31:0] wrap(input logic signed [32:0] a);
    logic signed [33:0] r;
    r = 34'(a);
    if (r > 34'sd411775) r = r - 34'sd411775;
    else if (r < -34'sd411775) r = r + 34'sd411775;
    if (r > 34'sd205887) r = r - 34'sd411775;
    if (r < -34'sd205887) r = r + 34'sd411775;
    wrap = r[31:0];
  endfunction

  // iterative angle reduction mod 2pi: subtract 2pi*2^k toward zero
  logic signed [33:0] red;
  logic [4:0]         red_k;
  logic               red_busy;
  logic signed [33:0] red_unit, red_adj;
  logic               red_ge;

  always_comb begin
    red_unit = 34'(bmvs_pkg::TWO_PI_Q) <<< red_k;
    red_ge = red[33] ? (-red >= red_unit) : (red >= red_unit);
    red_adj = red[33] ? red + red_unit : red - red_unit;
  end

  assign cmd.ready = (state == S_IDLE) && !red_busy;
  assign cor_angle = (cor_pass == 2'd1) ? red[31:0] : heading;
  assign num = 64'(tmp) * 64'(ss);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      throttle_gain <= 31'd65536; idle_force <= '0; brake_smoothing <= 17'd65536;
      static_brake_gain <= 31'd65536; dynamic_brake_gain <= 31'd65536;
      drag_coefficient <= '0; inverse_mass <= 31'd65536; inverse_wheelbase <= 31'd65536;
      throttle_target <= '0; brake_target <= bmvs_pkg::BRAKE_HOLD; brake_effort <= '0;
      speed <= '0; heading <= '0; steer_angle <= '0; steer_target <= '0;
      position_x <= '0; position_y <= '0;
      pose.valid <= 1'b0; cor_start <= 1'b0; div_start <= 1'b0;
      cor_pass <= '0; red_busy <= 1'b0; red_k <= '0;
    end else begin
      cor_start <= 1'b0; div_start <= 1'b0;
      // drop valid once the beat is taken, unless a new beat loads this cycle
      if (pose.valid && pose.ready && state != S_OUT) pose.valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          bmvs_pkg::REG_THROTTLE_GAIN: throttle_gain <= cfg_data;
          bmvs_pkg::REG_IDLE_FORCE:    idle_force <= cfg_data;
          bmvs_pkg::REG_BRAKE_SMOOTH:  brake_smoothing <= cfg_data[16:0];
          bmvs_pkg::REG_STATIC_BRAKE:  static_brake_gain <= cfg_data;
          bmvs_pkg::REG_DYNAMIC_BRAKE: dynamic_brake_gain <= cfg_data;
          bmvs_pkg::REG_DRAG:          drag_coefficient <= cfg_data;
          bmvs_pkg::REG_INV_MASS:      inverse_mass <= cfg_data;
          bmvs_pkg::REG_INV_WHEELBASE: inverse_wheelbase <= cfg_data;
          default: ;
        endcase
      end
      prod <= bmvs_pkg::sat32(prod_w);
      case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            case (cmd.func)
              bmvs_pkg::FUNC_TICK: begin dt <= cmd.time_step; state <= S_MOTOR; end
              bmvs_pkg::FUNC_ACCEL: begin
                throttle_target <= bmvs_pkg::sat32(66'(throttle_target) + 66'(cmd.amount));
                brake_target <= '0;
              end
              bmvs_pkg::FUNC_BRAKE: begin
                throttle_target <= '0;
                brake_target <= bmvs_pkg::sat32(66'(brake_target) + 66'(cmd.amount));
              end
              bmvs_pkg::FUNC_LEFT:
                if (steer_target < bmvs_pkg::STEER_LIMIT)
                  steer_target <= steer_target + bmvs_pkg::ONE_DEG;
              bmvs_pkg::FUNC_RIGHT:
                if (steer_target > -bmvs_pkg::STEER_LIMIT)
                  steer_target <= steer_target - bmvs_pkg::ONE_DEG;
              bmvs_pkg::FUNC_STOP: begin throttle_target <= '0; brake_target <= '0; end
              default: ;
            endcase
          end
        end
        S_MOTOR: state <= S_BEFF;
        S_BEFF: begin
          motor <= bmvs_pkg::sat32(66'(prod) + 66'(idle_force));
          state <= S_W1;
        end
        S_W1: begin
          brake_effort <= bmvs_pkg::sat32(66'(brake_effort) + 66'(prod));
          state <= S_BRAKE;
        end
        S_BRAKE: state <= S_DRAG1;
        S_DRAG1: begin
          if (speed < bmvs_pkg::NEAR_STOP && prod > motor)
            brake <= bmvs_pkg::sat32(66'(motor) + 66'(bmvs_pkg::Q_ONE));
          else brake <= prod;
          state <= S_DRAG2;
        end
        S_DRAG2: state <= S_W2;
        S_W2: begin
          tmp <= bmvs_pkg::sat32(66'(motor) - 66'(brake) - 66'(prod));
          state <= S_ACC;
        end
        S_ACC: state <= S_SPD;
        S_SPD: state <= S_STEER;
        S_STEER: begin
          begin : spd_upd
            logic signed [31:0] s;
            s = bmvs_pkg::sat32(66'(speed) + 66'(prod));
            speed <= s[31] ? 32'sd0 : s;
          end
          state <= S_W3;
        end
        S_W3: begin
          steer_angle <= bmvs_pkg::sat32(66'(steer_angle) + 66'(prod));
          cor_pass <= 2'd0; cor_start <= 1'b1; state <= S_TRIG1;
        end
        S_TRIG1: if (cor_done) begin
          ch <= cor_c; sh <= cor_s; state <= S_TPOS;
        end
        S_TPOS: state <= S_PX;
        S_PX: begin tpos <= prod; state <= S_PY; end
        S_PY: begin
          position_x <= bmvs_pkg::sat32(66'(position_x) + 66'(prod));
          // start steer angle reduction mod 2pi (truncating, magnitude-based)
          red <= 34'(steer_angle); red_k <= 5'd14; red_busy <= 1'b1;
          state <= S_TRIG2;
        end
        S_TRIG2: begin
          if (red_busy) begin
            if (red_ge) red <= red_adj;
            else if (red_k == 5'd0) begin
              red_busy <= 1'b0;
              red <= 34'(wrap(33'(red)));
              cor_pass <= 2'd1; cor_start <= 1'b1;
            end else red_k <= red_k - 5'd1;
          end else if (cor_done) begin
            cs <= cor_c; ss <= cor_s; state <= S_T1;
          end
          if (state == S_TRIG2 && red_k == 5'd14 && red == 34'(steer_angle))
            position_y <= bmvs_pkg::sat32(66'(position_y) + 66'(prod));
        end
        S_T1: state <= S_T2;
        S_T2: state <= S_DIV;
        S_DIV: begin tmp <= prod; div_start <= 1'b1; state <= S_HEAD; end
        S_HEAD: if (div_done) begin
          // reduce the full, unsaturated heading sum mod 2pi
          red <= 34'(heading) + 34'(quot); red_k <= 5'd14; red_busy <= 1'b1;
          state <= S_TRIG3;
        end
        S_TRIG3: begin
          if (red_busy) begin
            if (red_ge) red <= red_adj;
            else if (red_k == 5'd0) begin
              red_busy <= 1'b0;
              heading <= wrap(33'(red));
              cor_pass <= 2'd2; cor_start <= 1'b1;
            end else red_k <= red_k - 5'd1;
          end else if (cor_done) begin
            ch <= cor_c; sh <= cor_s; state <= S_VX;
          end
        end
        S_VX: state <= S_VY;
        S_VY: begin tmp <= prod; state <= S_OUT; end
        S_OUT: begin
          if (!pose.valid || pose.ready) begin
            pose.vel_x <= tmp; pose.vel_y <= prod;
            pose.pos_x <= position_x; pose.pos_y <= position_y;
            pose.dir_x <= ch; pose.dir_y <= sh; pose.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/bmvs_checker.sv
// Port-level checker for the vehicle step core, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module bmvs_checker (
  input wire clk,
  input wire rst,
  input wire cmd_ready,
  input wire pose_valid,
  input wire pose_ready,
  input wire signed [17:0] dir_x,
  input wire signed [17:0] dir_y
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_ready |=> pose_valid) else $error("pose beat dropped");
  a_dir: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> (dir_x <= 18'sd65536 && dir_x >= -18'sd65536))
    else $error("dir_x out of range");
  a_diry: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> (dir_y <= 18'sd65536 && dir_y >= -18'sd65536))
    else $error("dir_y out of range");
  a_rst: assert property (@(posedge clk) rst |=> !pose_valid)
    else $error("pose valid after reset");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(!cmd_ready))
    else $error("pose beat raised while idle");
endmodule

bind bicycle_model_vehicle_step_core bmvs_checker u_chk (
  .clk(clk), .rst(rst), .cmd_ready(cmd.ready),
  .pose_valid(pose.valid), .pose_ready(pose.ready),
  .dir_x(pose.dir_x), .dir_y(pose.dir_y));
`default_nettype wire
